// ===== hdl/mme_pkg.sv =====
package mme_pkg;

    // fixed width of every field port
    localparam int FIELD_W = 32;

    // default sizes handed to the top level
    localparam int MOD_BITS_DEF = 32;
    localparam int EXP_BITS_DEF = 32;

    // modulus after reset
    localparam logic [63:0] MOD_RESET = 64'd1000000007;

    // sequencer state codes
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RED  = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_SQR  = 2'd3;

endpackage

// ===== hdl/modular_exponentiation.sv =====
// modular exponentiation, right-to-left square-and-multiply
//
// input channel: pulse start while busy is low; i_base_value and i_exponent
//   are taken at that edge and the item is accepted. busy stays high until
//   the result comes out.
// result channel: o_power_result is shown for exactly one cycle with o_valid
//   high; the receiver cannot stall, so nothing waits on it.
// config: i_cfg_we writes i_cfg_data into the modulus at the clock edge;
//   write only while busy is low.
// work: one shared bit-serial modular multiplier does all the work. an item
//   costs one base reduction, one multiply per set exponent bit and one
//   square per exponent bit below the top set bit. exponent zero costs only
//   the base reduction, and a modulus of one or zero gives 0 in the cycle
//   after start.
// throughput: one item at a time, the next start is taken once busy drops.
// reset (synchronous, active low): sequencer idle, no result pending,
//   modulus back to 1000000007.
module modular_exponentiation
    import mme_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF,
    parameter int EXP_BITS = EXP_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [FIELD_W-1:0] i_cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [FIELD_W-1:0] i_base_value,
    input  logic [FIELD_W-1:0] i_exponent,
    output logic               o_valid,
    output logic [FIELD_W-1:0] o_power_result
);

    // sequencer and operand registers
    logic [1:0]          r_state, n_state;
    logic [MOD_BITS-1:0] r_mod, n_mod;
    logic [MOD_BITS-1:0] r_power, n_power;
    logic [MOD_BITS-1:0] r_result, n_result;
    logic [EXP_BITS-1:0] r_exp, n_exp;
    logic [MOD_BITS-1:0] r_out, n_out;
    logic                r_valid, n_valid;

    // field ports resized to the internal widths (zero extend or truncate)
    logic [FIELD_W+MOD_BITS-1:0] cfg_ext;
    logic [FIELD_W+MOD_BITS-1:0] base_ext;
    logic [FIELD_W+EXP_BITS-1:0] exp_ext;
    logic [FIELD_W+MOD_BITS-1:0] out_ext;
    logic [MOD_BITS-1:0]         cfg_m;
    logic [MOD_BITS-1:0]         base_m;
    logic [EXP_BITS-1:0]         exp_m;
    logic [EXP_BITS-1:0]         exp_next;
    logic                        mod_le1;

    // shared multiplier hookup
    logic                mul_start;
    logic [MOD_BITS-1:0] mul_a;
    logic [MOD_BITS-1:0] mul_b;
    logic                mul_done;
    logic [MOD_BITS-1:0] mul_prod;

    assign cfg_ext  = {{MOD_BITS{1'b0}}, i_cfg_data};
    assign base_ext = {{MOD_BITS{1'b0}}, i_base_value};
    assign exp_ext  = {{EXP_BITS{1'b0}}, i_exponent};
    assign cfg_m    = cfg_ext[MOD_BITS-1:0];
    assign base_m   = base_ext[MOD_BITS-1:0];
    assign exp_m    = exp_ext[EXP_BITS-1:0];
    assign exp_next = r_exp >> 1;

    // modulus of one (or zero) collapses every result to zero
    assign mod_le1 = (r_mod >> 1) == '0;

    mme_mulmod #(
        .MOD_BITS (MOD_BITS)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_m     (r_mod),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    always_comb begin
        n_state   = r_state;
        n_power   = r_power;
        n_result  = r_result;
        n_exp     = r_exp;
        n_out     = r_out;
        n_valid   = 1'b0;
        mul_start = 1'b0;
        mul_a     = r_power;
        mul_b     = r_result;

        // config writes are expected only while idle
        n_mod = i_cfg_we ? cfg_m : r_mod;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (mod_le1) begin
                        n_out   = '0;
                        n_valid = 1'b1;
                    end else begin
                        // base mod m as the product 1 * base
                        mul_start = 1'b1;
                        mul_a     = MOD_BITS'(1);
                        mul_b     = base_m;
                        n_result  = MOD_BITS'(1);
                        n_exp     = exp_m;
                        n_state   = S_RED;
                    end
                end
            end
            S_RED: begin
                if (mul_done) begin
                    n_power = mul_prod;
                    if (r_exp == '0) begin
                        // exponent zero: result stays 1
                        n_out   = r_result;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end else if (r_exp[0]) begin
                        mul_start = 1'b1;
                        mul_a     = mul_prod;
                        mul_b     = r_result;
                        n_state   = S_MUL;
                    end else begin
                        mul_start = 1'b1;
                        mul_a     = mul_prod;
                        mul_b     = mul_prod;
                        n_state   = S_SQR;
                    end
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    n_result = mul_prod;
                    if (exp_next == '0) begin
                        // no set bits left, the remaining squares do not matter
                        n_out   = mul_prod;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        mul_start = 1'b1;
                        mul_a     = r_power;
                        mul_b     = r_power;
                        n_state   = S_SQR;
                    end
                end
            end
            S_SQR: begin
                if (mul_done) begin
                    // a square is only issued while higher bits remain set
                    n_power = mul_prod;
                    n_exp   = exp_next;
                    mul_start = 1'b1;
                    mul_a     = mul_prod;
                    if (exp_next[0]) begin
                        mul_b   = r_result;
                        n_state = S_MUL;
                    end else begin
                        mul_b   = mul_prod;
                        n_state = S_SQR;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_mod   <= MOD_BITS'(MOD_RESET);
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_mod   <= n_mod;
        end
        r_power  <= n_power;
        r_result <= n_result;
        r_exp    <= n_exp;
        r_out    <= n_out;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign out_ext        = {{FIELD_W{1'b0}}, r_out};
    assign o_power_result = out_ext[FIELD_W-1:0];

    // every accepted item either finishes at once or keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted item neither busy nor finished");

    // a result comes only from a running item or a trivial-modulus start
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) != S_IDLE || $past(start)))
        else $error("result without an item");

    // the block is ready again in the cycle the result shows
    a_valid_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("busy still high with result");

endmodule

// ===== hdl/mme_mulmod.sv =====
module mme_mulmod
    import mme_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MOD_BITS-1:0] i_a,
    input  logic [MOD_BITS-1:0] i_b,
    input  logic [MOD_BITS-1:0] i_m,
    output logic                o_done,
    output logic [MOD_BITS-1:0] o_prod
);

    localparam int CNT_W = $clog2(MOD_BITS + 1);
    localparam int SUM_W = MOD_BITS + 2;

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [MOD_BITS-1:0] r_acc, n_acc;
    logic [MOD_BITS-1:0] r_a, n_a;
    logic [MOD_BITS-1:0] r_b, n_b;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] m1;
    logic [SUM_W-1:0] m2;
    logic [SUM_W-1:0] red;

    // horner step: acc = (2*acc + bit*a) mod m, below 3m so one subtract of 2m or m is enough
    always_comb begin
        m1  = {2'b00, i_m};
        m2  = {1'b0, i_m, 1'b0};
        sum = {1'b0, r_acc, 1'b0} + (r_b[MOD_BITS-1] ? {2'b00, r_a} : '0);
        if (sum >= m2) begin
            red = sum - m2;
        end else if (sum >= m1) begin
            red = sum - m1;
        end else begin
            red = sum;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(MOD_BITS);
            n_acc  = '0;
            n_a    = i_a;
            n_b    = i_b;
        end else if (r_busy) begin
            n_acc = red[MOD_BITS-1:0];
            n_b   = r_b << 1;
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("product started while unit busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held longer than one cycle");

    a_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_cnt == CNT_W'(1)) |=> (r_done && !r_busy))
        else $error("final step did not raise done");

endmodule
